### rtl/core/wts_pkg.sv
// wts_pkg: shared types and constants of the world-to-screen projection block.
// Item structs, command and register codes, reset values.
// No dependencies.
package wts_pkg;

    // fraction bits of every fixed-point field
    localparam int FRAC_BITS = 16;

    // input and output field widths
    localparam int CMD_W    = 1;
    localparam int CIDX_W   = 4;
    localparam int WORD_W   = 32;
    localparam int SCREEN_W = 14;
    localparam int HALF_W   = SCREEN_W - 1;
    localparam int MINW_W   = 31;

    // commands
    localparam logic [CMD_W-1:0] CMD_LOAD    = 1'b0;
    localparam logic [CMD_W-1:0] CMD_PROJECT = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_W  = 2'd2;

    // register reset values (min_clip_w: 0.1 in unsigned Q15.16)
    localparam logic [SCREEN_W-1:0] WIDTH_RST  = 14'd1920;
    localparam logic [SCREEN_W-1:0] HEIGHT_RST = 14'd1080;
    localparam logic [MINW_W-1:0]   MIN_W_RST  = 31'd6554;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [CIDX_W-1:0]        coeff_index;
        logic signed [WORD_W-1:0] coeff_value;
        logic signed [WORD_W-1:0] pos_x;
        logic signed [WORD_W-1:0] pos_y;
        logic signed [WORD_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic                     visible;
        logic signed [WORD_W-1:0] screen_x;
        logic signed [WORD_W-1:0] screen_y;
    } t_out_item;

endpackage

### rtl/core/world_to_screen_projection.sv
// world_to_screen_projection: 4x4 matrix projection of world points to screen pixels.
// One shared 33x33 multiplier, a restoring divider and a one-hot sequencer.
// Depends on wts_pkg.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | i_in_valid/o_in_stall | wts_pkg::t_in_item
//  out     | output    | o_out_valid/i_out_stall | wts_pkg::t_out_item
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load item is written when it is accepted, and the block stays ready for the next item.
// A project item runs the x, y and w clip rows, each an init step and a multiply/add pair
// per coordinate, then the threshold check, then per axis a multiply/add pair per partial
// product, the one-bit-per-cycle divider for KQ quotient bits (KQ=32 at FRAC_BITS=16)
// and a combine step, then the output step. A point behind the clip threshold goes from
// the check to the output, and an axis whose quotient overflows skips its divider.
// Reset is synchronous; it clears the matrix to zero and the registers to their defaults.
// A result held by a stalled output register only holds the sequencer in its last state.
module world_to_screen_projection (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  wts_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output wts_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wts_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wts_pkg::WORD_W-1:0]          i_cfg_data
);

    localparam int FRAC_BITS = wts_pkg::FRAC_BITS;
    localparam int WORD_W = wts_pkg::WORD_W;
    localparam int MUL_W  = WORD_W + 1;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int CLIP_W = ACC_W - FRAC_BITS;
    localparam int HI_W   = CLIP_W - WORD_W;
    // quotient bits kept; anything at or above 2^KQ saturates the output
    localparam int KQ     = ((FRAC_BITS + wts_pkg::HALF_W) > 31 ?
                             (FRAC_BITS + wts_pkg::HALF_W) : 31) + 1;
    localparam int CNT_W  = $clog2(KQ);
    localparam int SUM_W  = KQ + 2;

    localparam logic [1:0] ROW_X = 2'd0;
    localparam logic [1:0] ROW_Y = 2'd1;
    localparam logic [1:0] ROW_W = 2'd3;
    localparam logic [1:0] COL_LAST = 2'd2;
    localparam logic [1:0] COL_OFS  = 2'd3;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_INIT = 10'b0000000010,
        S_MUL  = 10'b0000000100,
        S_ADD  = 10'b0000001000,
        S_CHK  = 10'b0000010000,
        S_VMUL = 10'b0000100000,
        S_VADD = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_FIN  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    function automatic logic [CLIP_W-1:0] abs_clip(input logic signed [CLIP_W-1:0] c);
        abs_clip = c[CLIP_W-1] ? unsigned'(-c) : unsigned'(c);
    endfunction

    // control state
    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic [wts_pkg::SCREEN_W-1:0] r_width, r_height;
    logic [wts_pkg::MINW_W-1:0]   r_min_w;
    logic signed [WORD_W-1:0]     r_mtx [16];

    // datapath
    logic [1:0]               r_row, n_row, r_col, n_col;
    logic signed [WORD_W-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y, r_pos_z, n_pos_z;
    logic signed [ACC_W-1:0]  r_acc, n_acc, r_prod, n_prod;
    logic signed [CLIP_W-1:0] r_cx, n_cx, r_cy, n_cy, r_cw, n_cw;
    logic                     r_neg, n_neg, r_axis, n_axis, r_part, n_part, r_ovf, n_ovf;
    logic [CLIP_W-1:0]        r_mag, n_mag, r_rem, n_rem;
    logic [wts_pkg::HALF_W-1:0] r_half, n_half;
    logic [KQ-1:0]            r_low, n_low;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_vis, n_vis;
    logic signed [WORD_W-1:0] r_sx, n_sx, r_sy, n_sy;
    wts_pkg::t_out_item       r_out_data, n_out_data;

    logic                     in_accept, mtx_we, cfg_we;
    logic signed [WORD_W-1:0] m_rd, pos_sel;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  mac_sum, mac_shr, init_val, num_sum;
    logic signed [CLIP_W-1:0] clip_val;
    logic [ACC_W-1:0]         num, div_r0, w_ext;
    logic                     div_ovf, cw_low, take;
    logic [CLIP_W:0]          trial, w_div, diff;
    logic [KQ:0]              t_mag;
    logic signed [SUM_W-1:0]  base, t_s, fin_sum;
    logic signed [WORD_W-1:0] fin_sat;

    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign mtx_we      = in_accept && (i_in_data.cmd == wts_pkg::CMD_LOAD);
    assign cfg_we      = i_cfg_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // shared multiplier operands
    assign m_rd = r_mtx[{r_row, r_col}];
    always_comb begin
        case (r_col)
            2'd0:    pos_sel = r_pos_x;
            2'd1:    pos_sel = r_pos_y;
            default: pos_sel = r_pos_z;
        endcase
        if (r_state == S_MUL) begin
            mul_a = MUL_W'(m_rd);
            mul_b = MUL_W'(pos_sel);
        end else begin
            mul_a = r_part ? $signed({{(MUL_W-HI_W){1'b0}}, r_mag[CLIP_W-1:WORD_W]})
                           : $signed({1'b0, r_mag[WORD_W-1:0]});
            mul_b = $signed({{(MUL_W-wts_pkg::HALF_W){1'b0}}, r_half});
        end
    end

    // clip rows: floor((sum of products + m3*2^F) / 2^F)
    assign mac_sum  = r_acc + r_prod;
    assign mac_shr  = mac_sum >>> FRAC_BITS;
    assign clip_val = mac_shr[CLIP_W-1:0];
    assign init_val = ACC_W'(m_rd) <<< FRAC_BITS;
    assign cw_low   = r_cw <= $signed({{(CLIP_W-wts_pkg::MINW_W){1'b0}}, r_min_w});

    // numerator half*|c| from two partial products, then divider setup
    assign num_sum = r_acc + (r_prod <<< WORD_W);
    assign num     = unsigned'(num_sum);
    assign div_r0  = num >> (KQ - FRAC_BITS);
    assign w_ext   = ACC_W'(unsigned'(r_cw));
    assign div_ovf = div_r0 >= w_ext;

    // restoring step
    assign trial = {r_rem, r_low[KQ-1]};
    assign w_div = {1'b0, unsigned'(r_cw)};
    assign take  = trial >= w_div;
    assign diff  = trial - w_div;

    // viewport combine and saturation
    assign t_mag   = r_ovf ? {1'b1, {KQ{1'b0}}} : {1'b0, r_low};
    assign base    = $signed(SUM_W'(r_half) << FRAC_BITS);
    assign t_s     = $signed(SUM_W'(t_mag));
    assign fin_sum = (r_neg ^ r_axis) ? (base - t_s) : (base + t_s);
    always_comb begin
        if (&fin_sum[SUM_W-1:WORD_W-1] || ~|fin_sum[SUM_W-1:WORD_W-1]) begin
            fin_sat = fin_sum[WORD_W-1:0];
        end else if (fin_sum[SUM_W-1]) begin
            fin_sat = $signed({1'b1, {(WORD_W-1){1'b0}}});
        end else begin
            fin_sat = $signed({1'b0, {(WORD_W-1){1'b1}}});
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_row   = r_row;
        n_col   = r_col;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cw    = r_cw;
        n_neg   = r_neg;
        n_axis  = r_axis;
        n_part  = r_part;
        n_ovf   = r_ovf;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_half  = r_half;
        n_low   = r_low;
        n_cnt   = r_cnt;
        n_vis   = r_vis;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_out_data = r_out_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (i_in_data.cmd == wts_pkg::CMD_PROJECT)) begin
                    n_pos_x = i_in_data.pos_x;
                    n_pos_y = i_in_data.pos_y;
                    n_pos_z = i_in_data.pos_z;
                    n_row   = ROW_X;
                    n_col   = COL_OFS;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                n_acc   = init_val;
                n_col   = 2'd0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc = mac_sum;
                if (r_col == COL_LAST) begin
                    case (r_row)
                        ROW_X:   n_cx = clip_val;
                        ROW_Y:   n_cy = clip_val;
                        default: n_cw = clip_val;
                    endcase
                    n_col   = COL_OFS;
                    n_row   = (r_row == ROW_Y) ? ROW_W : r_row + 2'd1;
                    n_state = (r_row == ROW_W) ? S_CHK : S_INIT;
                end else begin
                    n_col   = r_col + 2'd1;
                    n_state = S_MUL;
                end
            end
            S_CHK: begin
                if (cw_low) begin
                    n_vis   = 1'b0;
                    n_sx    = '0;
                    n_sy    = '0;
                    n_state = S_OUT;
                end else begin
                    n_vis   = 1'b1;
                    n_axis  = 1'b0;
                    n_part  = 1'b0;
                    n_neg   = r_cx[CLIP_W-1];
                    n_mag   = abs_clip(r_cx);
                    n_half  = r_width[wts_pkg::SCREEN_W-1:1];
                    n_state = S_VMUL;
                end
            end
            S_VMUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_VADD;
            end
            S_VADD: begin
                if (!r_part) begin
                    n_acc   = r_prod;
                    n_part  = 1'b1;
                    n_state = S_VMUL;
                end else begin
                    n_ovf   = div_ovf;
                    n_rem   = div_r0[CLIP_W-1:0];
                    n_low   = {num[KQ-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
                    n_cnt   = '0;
                    // quotient too large: skip the divider, the output saturates
                    n_state = div_ovf ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                n_rem = take ? diff[CLIP_W-1:0] : trial[CLIP_W-1:0];
                n_low = {r_low[KQ-2:0], take};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(KQ - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_axis) begin
                    n_sx    = fin_sat;
                    n_axis  = 1'b1;
                    n_part  = 1'b0;
                    n_neg   = r_cy[CLIP_W-1];
                    n_mag   = abs_clip(r_cy);
                    n_half  = r_height[wts_pkg::SCREEN_W-1:1];
                    n_state = S_VMUL;
                end else begin
                    n_sy    = fin_sat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data.visible  = r_vis;
                    n_out_data.screen_x = r_sx;
                    n_out_data.screen_y = r_sy;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= wts_pkg::WIDTH_RST;
            r_height    <= wts_pkg::HEIGHT_RST;
            r_min_w     <= wts_pkg::MIN_W_RST;
            for (int i = 0; i < 16; i++) begin
                r_mtx[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_we) begin
                unique case (i_cfg_index)
                    wts_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[wts_pkg::SCREEN_W-1:0];
                    wts_pkg::CFG_HEIGHT: r_height <= i_cfg_data[wts_pkg::SCREEN_W-1:0];
                    wts_pkg::CFG_MIN_W:  r_min_w  <= i_cfg_data[wts_pkg::MINW_W-1:0];
                    default: ;
                endcase
            end
            if (mtx_we) begin
                r_mtx[i_in_data.coeff_index] <= i_in_data.coeff_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row   <= n_row;
        r_col   <= n_col;
        r_pos_x <= n_pos_x;
        r_pos_y <= n_pos_y;
        r_pos_z <= n_pos_z;
        r_acc   <= n_acc;
        r_prod  <= n_prod;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cw    <= n_cw;
        r_neg   <= n_neg;
        r_axis  <= n_axis;
        r_part  <= n_part;
        r_ovf   <= n_ovf;
        r_mag   <= n_mag;
        r_rem   <= n_rem;
        r_half  <= n_half;
        r_low   <= n_low;
        r_cnt   <= n_cnt;
        r_vis   <= n_vis;
        r_sx    <= n_sx;
        r_sy    <= n_sy;
        r_out_data <= n_out_data;
    end

endmodule

### rtl/core/wts_checker.sv
// wts_checker: port-level assertions for world_to_screen_projection, and its bind.
// Watches the item, result and configuration channels only.
// Depends on wts_pkg.
module wts_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input wts_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input wts_pkg::t_out_item            o_out_data,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [wts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [wts_pkg::WORD_W-1:0]    i_cfg_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && !o_in_stall;

    // a result stalled by the receiver holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // a point behind the threshold reports zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.visible |->
            o_out_data.screen_x == 0 && o_out_data.screen_y == 0)
        else $error("hidden point with nonzero coordinates");

    // a project transfer occupies the block
    a_project_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.cmd == wts_pkg::CMD_PROJECT |=> o_in_stall)
        else $error("not busy after a project transfer");

    // a coefficient load leaves the block ready in the cycle after its transfer
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.cmd == wts_pkg::CMD_LOAD |=> !o_in_stall)
        else $error("stalled after a coefficient load");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready && ($countones(i_cfg_index) <= 2) && ($bits(i_cfg_data) > 0))
        else $error("configuration write refused");

endmodule

bind world_to_screen_projection wts_checker u_wts_checker (.*);

### test/tb_world_to_screen_projection.sv
// tb_world_to_screen_projection: self-checking bench for the world-to-screen projection block.
// Predicts matrix loads and point projections in a scoreboard class and checks every result.
// Depends on wts_pkg and world_to_screen_projection.
module tb_world_to_screen_projection;
    import wts_pkg::*;

    localparam int FRAC = FRAC_BITS;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [WORD_W-1:0] ONE = 32'h0001_0000;
    localparam logic [WORD_W-1:0] MAX_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MAX_NEG = 32'h8000_0000;
    localparam int LONG_HOLD = 400;

    class projection_scoreboard;
        logic signed [WORD_W-1:0] coeff[16];
        logic [SCREEN_W-1:0] width_reg;
        logic [SCREEN_W-1:0] height_reg;
        logic [MINW_W-1:0] min_w_reg;
        t_out_item pending_points[$];
        int errors;

        function new();
            foreach (coeff[i]) coeff[i] = '0;
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            min_w_reg = MIN_W_RST;
            errors = 0;
        endfunction

        task report(input string what);
            if (errors < 50) $display("mismatch: %s", what);
            errors++;
        endtask

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
            case (idx)
                CFG_WIDTH: width_reg = data[SCREEN_W-1:0];
                CFG_HEIGHT: height_reg = data[SCREEN_W-1:0];
                CFG_MIN_W: min_w_reg = data[MINW_W-1:0];
                default: ;
            endcase
        endfunction

        // exact row sum, floored back to FRAC fraction bits
        function longint clip_row(input int r, input logic signed [WORD_W-1:0] x,
                                  input logic signed [WORD_W-1:0] y,
                                  input logic signed [WORD_W-1:0] z);
            longint px, py, pz, tr;
            logic signed [79:0] acc;
            px = longint'(coeff[4*r]) * longint'(x);
            py = longint'(coeff[4*r+1]) * longint'(y);
            pz = longint'(coeff[4*r+2]) * longint'(z);
            tr = longint'(coeff[4*r+3]) <<< FRAC;
            acc = 80'(px);
            acc = acc + 80'(py);
            acc = acc + 80'(pz);
            acc = acc + 80'(tr);
            acc = acc >>> FRAC;
            return longint'(acc);
        endfunction

        // (half * c) / w, truncated toward zero, integer part clamped at 2^33
        function longint view_term(input longint half, input longint c, input longint w);
            logic [63:0] mag, num, uw, q, r, t;
            logic [79:0] frac;
            mag = (c < 0) ? 64'(-c) : 64'(c);
            uw = w;
            num = mag * half;
            q = num / uw;
            r = num % uw;
            frac = ({16'd0, r} << FRAC) / {16'd0, uw};
            if (q > (64'd1 << 33)) q = 64'd1 << 33;
            t = (q << FRAC) | frac[63:0];
            return (c < 0) ? -longint'(t) : longint'(t);
        endfunction

        function logic [WORD_W-1:0] sat32(input longint v);
            if (v > 64'sd2147483647) return MAX_POS;
            if (v < -64'sd2147483648) return MAX_NEG;
            return v[31:0];
        endfunction

        function t_out_item project_point(input t_in_item it);
            longint cx, cy, cw, hw, hh, mw;
            t_out_item o;
            o = '0;
            cx = clip_row(0, it.pos_x, it.pos_y, it.pos_z);
            cy = clip_row(1, it.pos_x, it.pos_y, it.pos_z);
            cw = clip_row(3, it.pos_x, it.pos_y, it.pos_z);
            mw = 0;
            mw[MINW_W-1:0] = min_w_reg;
            if (cw > mw) begin
                hw = 0;
                hh = 0;
                hw[HALF_W-1:0] = width_reg[SCREEN_W-1:1];
                hh[HALF_W-1:0] = height_reg[SCREEN_W-1:1];
                o.visible = 1'b1;
                o.screen_x = sat32((hw <<< FRAC) + view_term(hw, cx, cw));
                o.screen_y = sat32((hh <<< FRAC) - view_term(hh, cy, cw));
            end
            return o;
        endfunction

        function void note_item(input t_in_item it);
            if (it.cmd == CMD_LOAD) coeff[it.coeff_index] = it.coeff_value;
            else pending_points.push_back(project_point(it));
        endfunction

        task check_point(input t_out_item got);
            t_out_item want;
            if (pending_points.size() == 0) begin
                report($sformatf("result with nothing pending: %h", got));
                return;
            end
            want = pending_points.pop_front();
            if (got.visible !== want.visible)
                report($sformatf("visible got %b want %b", got.visible, want.visible));
            if (got.screen_x !== want.screen_x)
                report($sformatf("screen_x got %h want %h", got.screen_x, want.screen_x));
            if (got.screen_y !== want.screen_y)
                report($sformatf("screen_y got %h want %h", got.screen_y, want.screen_y));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_in_item in_data = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;
    logic in_stall, out_valid, cfg_ready;
    t_out_item out_data;

    bit sender_idle = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_req = 1'b0;

    projection_scoreboard sb = new();

    world_to_screen_projection u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int rand_span(input int k);
        return int'($urandom_range(0, (1 << (k + 1)) - 1)) - (1 << k);
    endfunction

    function automatic t_in_item make_point(input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                                            input logic [WORD_W-1:0] z);
        t_in_item it;
        it.cmd = CMD_PROJECT;
        it.coeff_index = CIDX_W'($urandom);
        it.coeff_value = $urandom;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        return it;
    endfunction

    function automatic t_in_item make_load(input logic [CIDX_W-1:0] idx,
                                           input logic [WORD_W-1:0] value);
        t_in_item it;
        it.cmd = CMD_LOAD;
        it.coeff_index = idx;
        it.coeff_value = value;
        it.pos_x = $urandom;
        it.pos_y = $urandom;
        it.pos_z = $urandom;
        return it;
    endfunction

    // coefficients of a plausible perspective matrix: w row close to (0,0,1,t)
    function automatic logic [WORD_W-1:0] tame_coeff(input logic [CIDX_W-1:0] idx);
        case (idx)
            4'd12, 4'd13: return rand_span(12);
            4'd14: return ONE + rand_span(14);
            4'd15: return rand_span(16);
            default: return rand_span(17);
        endcase
    endfunction

    function automatic t_in_item random_point(input bit noisy);
        int sel;
        sel = $urandom_range(0, 19);
        if (noisy || sel == 0) return make_point($urandom, $urandom, $urandom);
        if (sel == 1) return make_point(rand_span(20), rand_span(20), MIN_W_RST + rand_span(3));
        if (sel == 2) return make_point(rand_span(20), rand_span(20), -$urandom_range(0, 1 << 20));
        return make_point(rand_span(20), rand_span(20), $urandom_range(1 << 14, 1 << 22));
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        sb.note_item(it);
        gap = sender_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // unused data bits are random, the block must mask them
    task automatic setup_viewport(input int w, input int h, input int mw);
        logic [WORD_W-1:0] d;
        d = $urandom;
        d[SCREEN_W-1:0] = w[SCREEN_W-1:0];
        write_reg(CFG_WIDTH, d);
        d = $urandom;
        d[SCREEN_W-1:0] = h[SCREEN_W-1:0];
        write_reg(CFG_HEIGHT, d);
        d = $urandom;
        d[MINW_W-1:0] = mw[MINW_W-1:0];
        write_reg(CFG_MIN_W, d);
        write_reg(CFG_UNUSED, $urandom);
    endtask

    // wait for every pending result, then let a trailing load settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_points.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : receiver
        int n;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            n = receiver_idle ? $urandom_range(0, 8) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                n = LONG_HOLD;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!out_valid);
            sb.check_point(out_data);
        end
    end

    initial begin : stimulus
        int w, h, mw, sel;
        bit noisy;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: zero matrix puts w at zero, below the default threshold
        send_item(make_point(0, 0, 0));
        send_item(make_load(4'd0, ONE));
        send_item(make_load(4'd5, ONE));
        send_item(make_load(4'd14, ONE));
        send_item(make_point(0, 0, ONE));
        send_item(make_point(ONE, -ONE, ONE));
        send_item(make_point(ONE, ONE, MIN_W_RST));
        send_item(make_point(ONE, ONE, MIN_W_RST + 1));
        send_item(make_point(0, 0, -ONE));
        send_item(make_point(MAX_POS, MAX_NEG, MAX_POS));
        send_item(make_load(4'd3, MAX_POS));
        send_item(make_load(4'd7, MAX_NEG));
        send_item(make_point(0, 0, ONE));
        // extreme product and a quotient far past the clamp
        send_item(make_load(4'd0, MAX_NEG));
        send_item(make_point(MAX_NEG, 0, MIN_W_RST + 1));
        send_item(make_load(4'd15, MAX_POS));
        send_item(make_point(MAX_NEG, MAX_POS, MAX_NEG));
        drain();
        // zero width and height collapse both halves
        setup_viewport(0, 0, 0);
        send_item(make_point(ONE, ONE, ONE));
        send_item(make_point(MAX_POS, MAX_NEG, 0));
        drain();
        setup_viewport(16383, 16383, 32'h7FFF_FFFF);
        send_item(make_point(0, 0, ONE));
        send_item(make_point(MAX_POS, MAX_POS, MAX_POS));
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin w = int'(WIDTH_RST); h = int'(HEIGHT_RST); mw = int'(MIN_W_RST); end
                1: begin w = 1; h = 1; mw = 0; end
                2: begin w = 8192; h = 8192; mw = 1 << 16; end
                3: begin w = 16383; h = 1; mw = 1; end
                default: begin
                    w = $urandom_range(1, 8192);
                    h = $urandom_range(1, 8192);
                    mw = $urandom_range(0, 1 << 17);
                end
            endcase
            setup_viewport(w, h, mw);
            sender_idle = (ph % 3) != 0;
            receiver_idle = (ph % 4) != 1;
            noisy = (ph == 3) || (ph == 6);
            for (int i = 0; i < 16; i++)
                send_item(make_load(i[CIDX_W-1:0], noisy ? $urandom : tame_coeff(i[CIDX_W-1:0])));
            for (int k = 0; k < 220; k++) begin
                if (ph == 2 && k == 40) hold_req = 1'b1;
                if (ph == 5 && k == 110) drain();
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    logic [CIDX_W-1:0] idx;
                    idx = CIDX_W'($urandom);
                    send_item(make_load(idx, (noisy || sel < 2) ? $urandom : tame_coeff(idx)));
                end else begin
                    send_item(random_point(noisy));
                end
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (sb.pending_points.size() != 0) sb.report("results never arrived");
        if (sb.errors == 0) $display("[world_to_screen_projection] OK");
        else $display("[world_to_screen_projection] ERROR");
        $finish;
    end

    initial begin : watchdog
        #(64'd12_000_000);
        $display("[world_to_screen_projection] ERROR");
        $finish;
    end

endmodule
